// ----- src/fci_pkg.sv -----
// Shared widths, codes and types of the flash command interface.
package fci_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKER_ID   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID  = 2'd2;

  localparam logic              RST_FLASH_MODE = 1'b1;
  localparam logic [DATA_W-1:0] RST_MAKER_ID   = 8'hBF;
  localparam logic [DATA_W-1:0] RST_DEVICE_ID  = 8'hD5;

  // Command sequence addresses and bytes
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK1     = 16'h5555;
  localparam logic [ADDR_W-1:0] ADDR_UNLOCK2     = 16'h2AAA;
  localparam logic [DATA_W-1:0] DAT_UNLOCK1      = 8'hAA;
  localparam logic [DATA_W-1:0] DAT_UNLOCK2      = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_ID_ENTER     = 8'h90;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT      = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_ERASE_SETUP  = 8'h80;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_STEP   = 3'd1,
    ST_PROG   = 3'd2,
    ST_SECTOR = 3'd3,
    ST_CHIP   = 3'd4,
    ST_ABORT  = 3'd5
  } status_t;

  // Classified bus access, as handed from front to back
  typedef struct packed {
    logic              is_write;
    logic              addr_odd;
    logic              at_unlock1;
    logic              at_unlock2;
    logic              d_unlock1;
    logic              d_unlock2;
    logic              d_program;
    logic              d_erase_setup;
    logic              d_id_enter;
    logic              d_id_exit;
    logic              d_chip_erase;
    logic              d_sector_erase;
    logic [DATA_W-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic              flash_mode;
    logic [DATA_W-1:0] maker_id;
    logic [DATA_W-1:0] device_id;
  } cfg_t;

endpackage

// ----- src/fci_in_if.sv -----
// Bus access channel: one read or write word.
interface fci_in_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [fci_pkg::ADDR_W-1:0]       address;
  logic [fci_pkg::DATA_W-1:0]       write_data;

  modport source (output valid, req_type, address, write_data, input ready);
  modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

// ----- src/fci_out_if.sv -----
// Result channel: read data and status word.
interface fci_out_if;
  logic                             valid;
  logic                             ready;
  logic [fci_pkg::DATA_W-1:0]       read_data;
  logic [fci_pkg::STATUS_W-1:0]     status;

  modport source (output valid, read_data, status, input ready);
  modport sink   (input valid, read_data, status, output ready);
endinterface

// ----- src/fci_cfg_if.sv -----
// Configuration write channel: register index and data word.
interface fci_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [fci_pkg::CFG_IDX_W-1:0]    index;
  logic [fci_pkg::DATA_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/fci_front.sv -----
// Front end: accept bus words, fold the address into the array, classify.
module fci_front #(
  parameter int unsigned MEM_DEPTH = 65536,
  parameter int unsigned IDX_W     = 16
) (
  fci_in_if.sink                 in_ch,
  input  logic                   busy,
  input  logic                   q_full,
  output logic                   push,
  output fci_pkg::cmd_t          cmd,
  output logic [IDX_W-1:0]       idx
);

  // Largest multiplier of the depth that a 16-bit address can reach
  localparam int unsigned QMAX = ((2 ** fci_pkg::ADDR_W) - 1) / MEM_DEPTH;

  logic [31:0] addr32;
  logic [31:0] base32;
  logic [31:0] rem32;

  assign in_ch.ready = !q_full && !busy;
  assign push        = in_ch.valid && in_ch.ready;

  // Address modulo depth: parallel compares against constant multiples
  always_comb begin
    addr32 = {16'b0, in_ch.address};
    base32 = '0;
    for (int k = 1; k <= QMAX; k++) begin
      if (addr32 >= 32'(k * MEM_DEPTH)) begin
        base32 = 32'(k * MEM_DEPTH);
      end
    end
    rem32 = addr32 - base32;
  end

  assign idx = rem32[IDX_W-1:0];

  always_comb begin
    cmd.is_write       = in_ch.req_type;
    cmd.addr_odd       = in_ch.address[0];
    cmd.at_unlock1     = in_ch.address == fci_pkg::ADDR_UNLOCK1;
    cmd.at_unlock2     = in_ch.address == fci_pkg::ADDR_UNLOCK2;
    cmd.d_unlock1      = in_ch.write_data == fci_pkg::DAT_UNLOCK1;
    cmd.d_unlock2      = in_ch.write_data == fci_pkg::DAT_UNLOCK2;
    cmd.d_program      = in_ch.write_data == fci_pkg::CMD_PROGRAM;
    cmd.d_erase_setup  = in_ch.write_data == fci_pkg::CMD_ERASE_SETUP;
    cmd.d_id_enter     = in_ch.write_data == fci_pkg::CMD_ID_ENTER;
    cmd.d_id_exit      = in_ch.write_data == fci_pkg::CMD_ID_EXIT;
    cmd.d_chip_erase   = in_ch.write_data == fci_pkg::CMD_CHIP_ERASE;
    cmd.d_sector_erase = in_ch.write_data == fci_pkg::CMD_SECTOR_ERASE;
    cmd.data           = in_ch.write_data;
  end

endmodule

// ----- src/fci_queue.sv -----
// Small FIFO between front and back.
module fci_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign full     = cnt_r == CNTW'(DEPTH);
  assign valid    = cnt_r != '0;
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CNTW'(1);
      2'b01:   cnt_nxt = cnt_r - CNTW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/fci_back.sv -----
// Back end: command sequencer, save memory, erase sweeps and result register.
module fci_back #(
  parameter int unsigned MEM_DEPTH   = 65536,
  parameter int unsigned SECTOR_SIZE = 4096,
  parameter int unsigned IDX_W       = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  fci_pkg::cmd_t        q_cmd,
  input  logic [IDX_W-1:0]     q_idx,
  output logic                 q_pop,
  input  fci_pkg::cfg_t        cfg,
  output logic                 clearing,
  fci_out_if.source            out_ch
);

  localparam int unsigned CW = $clog2(MEM_DEPTH + SECTOR_SIZE + 1);

  typedef enum logic [5:0] {
    B_CLEAR  = 6'b000001,
    B_IDLE   = 6'b000010,
    B_READ   = 6'b000100,
    B_PROG   = 6'b001000,
    B_LOCATE = 6'b010000,
    B_SWEEP  = 6'b100000
  } bstate_t;

  typedef enum logic [6:0] {
    SEQ_IDLE = 7'b0000001,
    SEQ_U1   = 7'b0000010,
    SEQ_U2   = 7'b0000100,
    SEQ_PRG  = 7'b0001000,
    SEQ_E0   = 7'b0010000,
    SEQ_E1   = 7'b0100000,
    SEQ_E2   = 7'b1000000
  } seq_t;

  logic [fci_pkg::DATA_W-1:0] mem [MEM_DEPTH];
  logic [fci_pkg::DATA_W-1:0] mem_q_r;

  bstate_t                    st_r, st_nxt;
  seq_t                       seq_r, seq_nxt;
  logic                       id_r, id_nxt;
  logic [CW-1:0]              ptr_r, ptr_nxt;
  logic [CW-1:0]              last_r, last_nxt;
  logic [CW-1:0]              ptr_plus;
  logic [IDX_W-1:0]           pend_idx_r, pend_idx_nxt;
  logic [fci_pkg::DATA_W-1:0] pend_data_r, pend_data_nxt;

  logic                       mem_we, mem_re;
  logic [IDX_W-1:0]           mem_waddr, mem_raddr;
  logic [fci_pkg::DATA_W-1:0] mem_wdata;

  logic                       out_valid_r;
  logic [fci_pkg::DATA_W-1:0] out_data_r;
  fci_pkg::status_t           out_status_r;
  logic                       slot_free;
  logic                       load;
  logic [fci_pkg::DATA_W-1:0] ld_data;
  fci_pkg::status_t           ld_status;

  assign clearing  = st_r == B_CLEAR;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign ptr_plus  = ptr_r + CW'(SECTOR_SIZE);

  always_comb begin
    st_nxt        = st_r;
    seq_nxt       = seq_r;
    id_nxt        = id_r;
    ptr_nxt       = ptr_r;
    last_nxt      = last_r;
    pend_idx_nxt  = pend_idx_r;
    pend_data_nxt = pend_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = q_idx;
    mem_raddr     = q_idx;
    mem_wdata     = q_cmd.data;
    load          = 1'b0;
    ld_data       = '0;
    ld_status     = fci_pkg::ST_OK;

    unique case (st_r) inside
      B_CLEAR, B_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[IDX_W-1:0];
        mem_wdata = fci_pkg::ERASED_BYTE;
        if (ptr_r == last_r) begin
          st_nxt = B_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      B_IDLE: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (!q_cmd.is_write) begin
            if (cfg.flash_mode && id_r) begin
              load    = 1'b1;
              ld_data = q_cmd.addr_odd ? cfg.device_id : cfg.maker_id;
            end else begin
              mem_re = 1'b1;
              st_nxt = B_READ;
            end
          end else if (!cfg.flash_mode) begin
            mem_we = 1'b1;
            load   = 1'b1;
          end else begin
            // Anything that does not fit the current step aborts to idle
            load      = 1'b1;
            ld_status = fci_pkg::ST_ABORT;
            seq_nxt   = SEQ_IDLE;
            unique case (seq_r)
              SEQ_IDLE: begin
                if (q_cmd.at_unlock1 && q_cmd.d_unlock1) begin
                  seq_nxt   = SEQ_U1;
                  ld_status = fci_pkg::ST_STEP;
                end else if (q_cmd.d_id_exit) begin
                  id_nxt    = 1'b0;
                  ld_status = fci_pkg::ST_STEP;
                end
              end
              SEQ_U1: begin
                if (q_cmd.at_unlock2 && q_cmd.d_unlock2) begin
                  seq_nxt   = SEQ_U2;
                  ld_status = fci_pkg::ST_STEP;
                end
              end
              SEQ_U2: begin
                if (q_cmd.at_unlock1) begin
                  if (q_cmd.d_program) begin
                    seq_nxt   = SEQ_PRG;
                    ld_status = fci_pkg::ST_STEP;
                  end else if (q_cmd.d_erase_setup) begin
                    seq_nxt   = SEQ_E0;
                    ld_status = fci_pkg::ST_STEP;
                  end else if (q_cmd.d_id_enter) begin
                    id_nxt    = 1'b1;
                    ld_status = fci_pkg::ST_STEP;
                  end else if (q_cmd.d_id_exit) begin
                    id_nxt    = 1'b0;
                    ld_status = fci_pkg::ST_STEP;
                  end
                end
              end
              SEQ_PRG: begin
                load          = 1'b0;
                mem_re        = 1'b1;
                pend_idx_nxt  = q_idx;
                pend_data_nxt = q_cmd.data;
                st_nxt        = B_PROG;
              end
              SEQ_E0: begin
                if (q_cmd.at_unlock1 && q_cmd.d_unlock1) begin
                  seq_nxt   = SEQ_E1;
                  ld_status = fci_pkg::ST_STEP;
                end
              end
              SEQ_E1: begin
                if (q_cmd.at_unlock2 && q_cmd.d_unlock2) begin
                  seq_nxt   = SEQ_E2;
                  ld_status = fci_pkg::ST_STEP;
                end
              end
              SEQ_E2: begin
                if (q_cmd.at_unlock1 && q_cmd.d_chip_erase) begin
                  ld_status = fci_pkg::ST_CHIP;
                  ptr_nxt   = '0;
                  last_nxt  = CW'(MEM_DEPTH - 1);
                  st_nxt    = B_SWEEP;
                end else if (q_cmd.d_sector_erase) begin
                  ld_status    = fci_pkg::ST_SECTOR;
                  ptr_nxt      = '0;
                  pend_idx_nxt = q_idx;
                  st_nxt       = B_LOCATE;
                end
              end
              default: begin
                seq_nxt = SEQ_IDLE;
              end
            endcase
          end
        end
      end

      B_READ: begin
        load    = 1'b1;
        ld_data = mem_q_r;
        st_nxt  = B_IDLE;
      end

      B_PROG: begin
        mem_we    = 1'b1;
        mem_waddr = pend_idx_r;
        mem_wdata = mem_q_r & pend_data_r;
        load      = 1'b1;
        ld_status = fci_pkg::ST_PROG;
        st_nxt    = B_IDLE;
      end

      B_LOCATE: begin
        // Step the sector base up until it holds the target byte
        if (ptr_plus <= CW'(pend_idx_r)) begin
          ptr_nxt = ptr_plus;
        end else begin
          last_nxt = (ptr_plus > CW'(MEM_DEPTH)) ? CW'(MEM_DEPTH - 1) : ptr_plus - CW'(1);
          st_nxt   = B_SWEEP;
        end
      end

      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_CLEAR;
      seq_r       <= SEQ_IDLE;
      id_r        <= 1'b0;
      ptr_r       <= '0;
      last_r      <= CW'(MEM_DEPTH - 1);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      seq_r       <= seq_nxt;
      id_r        <= id_nxt;
      ptr_r       <= ptr_nxt;
      last_r      <= last_nxt;
      out_valid_r <= load || (out_valid_r && !out_ch.ready);
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    pend_data_r <= pend_data_nxt;
    if (load) begin
      out_data_r   <= ld_data;
      out_status_r <= ld_status;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.read_data = out_data_r;
  assign out_ch.status    = out_status_r;

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten while held");

  a_wait_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_READ || st_r == B_PROG) |-> !out_valid_r)
    else $error("deferred result with result register occupied");

  a_clear_noq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_CLEAR) |-> !q_valid)
    else $error("word queued during clearing pass");

  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_SWEEP || st_r == B_CLEAR) |-> (ptr_r <= last_r))
    else $error("sweep pointer past its end");

  a_prog_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == B_PROG) |-> (seq_r == SEQ_IDLE))
    else $error("sequence not back to idle after program");
`endif

endmodule

// ----- src/flash_command_interface_top.sv -----
// Top level of the byte-wide save memory with flash command sequences.
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+------------
//  in_ch    | in  | req_type, address[15:0], write_data[7:0] | valid/ready
//  out_ch   | out | read_data[7:0], status[2:0]              | valid/ready
//  cfg_ch   | in  | index[1:0], data[7:0]                    | valid/ready
//
// Steps: a write or ID-mode read is answered from idle; a memory read or
// program passes through B_READ or B_PROG (registered RAM read). Chip erase
// sweeps the whole array; sector erase first locates the sector base, then
// sweeps that sector. Reset: a clearing pass fills FF, in_ch.ready low.
// Stalls: a two-word queue parts front and back; out_ch holds its word until
// taken while the front keeps filling the queue. cfg_ch is always ready.
module flash_command_interface_top #(
  parameter int unsigned MEM_DEPTH   = 65536,
  parameter int unsigned SECTOR_SIZE = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  fci_in_if.sink      in_ch,
  fci_out_if.source   out_ch,
  fci_cfg_if.sink     cfg_ch
);

  localparam int unsigned IDX_W = $clog2(MEM_DEPTH);
  localparam int unsigned QW    = $bits(fci_pkg::cmd_t) + IDX_W;

  fci_pkg::cfg_t    cfg_r;
  fci_pkg::cmd_t    f_cmd, q_cmd;
  logic [IDX_W-1:0] f_idx, q_idx;
  logic             push, q_full, q_valid, q_pop, clearing;

  // Register writes must land only while the block is quiet; the block does not enforce this and takes them always
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flash_mode <= fci_pkg::RST_FLASH_MODE;
      cfg_r.maker_id   <= fci_pkg::RST_MAKER_ID;
      cfg_r.device_id  <= fci_pkg::RST_DEVICE_ID;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        fci_pkg::CFG_FLASH_MODE: cfg_r.flash_mode <= cfg_ch.data[0];
        fci_pkg::CFG_MAKER_ID:   cfg_r.maker_id   <= cfg_ch.data;
        fci_pkg::CFG_DEVICE_ID:  cfg_r.device_id  <= cfg_ch.data;
        default: begin
          // drop writes to unknown indexes
        end
      endcase
    end
  end

  // Front: fold address, classify the word, push into the queue
  fci_front #(
    .MEM_DEPTH (MEM_DEPTH),
    .IDX_W     (IDX_W)
  ) u_front (
    .in_ch  (in_ch),
    .busy   (clearing),
    .q_full (q_full),
    .push   (push),
    .cmd    (f_cmd),
    .idx    (f_idx)
  );

  // Queue: hold classified words while the back end sweeps or stalls
  fci_queue #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({f_cmd, f_idx}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  ({q_cmd, q_idx})
  );

  // Back: advance the command sequence, access the array, drive results
  fci_back #(
    .MEM_DEPTH   (MEM_DEPTH),
    .SECTOR_SIZE (SECTOR_SIZE),
    .IDX_W       (IDX_W)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_idx    (q_idx),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
